>>> src/bef_pkg.sv
// Shared types and constants for the bounded event FIFO.
// Used by every module of the block; depends on nothing else.
package bef_pkg;

  localparam int PAYLOAD_W   = 32;
  localparam int SEQ_W       = 64;
  localparam int FIELD7_W    = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [FIELD7_W-1:0] CAPACITY_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_STOP    = 2'd2,
    CMD_DISCARD = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_STOPPED   = 3'd2,
    ST_ITEM      = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_DISCARDED = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [PAYLOAD_W-1:0] payload;
    logic [FIELD7_W-1:0]  max_batch;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [PAYLOAD_W-1:0] item_payload;
    logic [SEQ_W-1:0]     item_sequence;
    logic                 last;
    logic [FIELD7_W-1:0]  occupancy;
    logic [FIELD7_W-1:0]  high_watermark;
  } res_t;

  // Classified operation passed from the front end to the back end.
  // For a pop, count is the number of items and occupancy the fill before it.
  typedef struct packed {
    status_t              status;
    logic [PAYLOAD_W-1:0] payload;
    logic [SEQ_W-1:0]     seq_num;
    logic [FIELD7_W-1:0]  count;
    logic [FIELD7_W-1:0]  occupancy;
    logic [FIELD7_W-1:0]  high_watermark;
  } op_t;

endpackage

>>> src/bef_front.sv
// Front end of the bounded event FIFO: takes commands, keeps the fill
// count, watermark, sequence counter and stop flag, and classifies each
// command into one operation. Depends on bef_pkg.
module bef_front #(
  parameter int RING_DEPTH = 64,
  parameter int MAX_BATCH  = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  bef_pkg::req_t                 request,
  input  logic                          cfg_write,
  input  logic [bef_pkg::FIELD7_W-1:0]  cfg_data,
  output bef_pkg::op_t                  op
);

  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int KW = (CW > bef_pkg::FIELD7_W) ? CW : bef_pkg::FIELD7_W;

  logic [bef_pkg::FIELD7_W-1:0] capacity;
  logic [CW-1:0]                held, held_next;
  logic [CW-1:0]                peak, peak_next;
  logic [bef_pkg::SEQ_W-1:0]    seq_count, seq_count_next;
  logic                         stopped, stopped_next;

  logic [KW-1:0]                cap_eff;
  logic [KW-1:0]                held_k;
  logic [bef_pkg::FIELD7_W-1:0] batch_eff;
  logic [bef_pkg::FIELD7_W-1:0] pop_count;
  logic [CW-1:0]                held_inc;

  always_comb begin
    // Capacity zero counts as one; above the ring it saturates.
    if (capacity == '0) begin
      cap_eff = KW'(1);
    end else if (KW'(capacity) > KW'(RING_DEPTH)) begin
      cap_eff = KW'(RING_DEPTH);
    end else begin
      cap_eff = KW'(capacity);
    end
    if (request.max_batch == '0) begin
      batch_eff = bef_pkg::FIELD7_W'(1);
    end else if (request.max_batch > bef_pkg::FIELD7_W'(MAX_BATCH)) begin
      batch_eff = bef_pkg::FIELD7_W'(MAX_BATCH);
    end else begin
      batch_eff = request.max_batch;
    end
    held_k    = KW'(held);
    pop_count = (held_k < KW'(batch_eff)) ? bef_pkg::FIELD7_W'(held) : batch_eff;
    held_inc  = held + CW'(1);
  end

  always_comb begin
    held_next      = held;
    peak_next      = peak;
    seq_count_next = seq_count;
    stopped_next   = stopped;
    op.status         = bef_pkg::ST_STOPPED;
    op.payload        = '0;
    op.seq_num        = '0;
    op.count          = '0;
    op.occupancy      = bef_pkg::FIELD7_W'(held);
    op.high_watermark = bef_pkg::FIELD7_W'(peak);
    unique case (bef_pkg::cmd_t'(request.cmd))
      bef_pkg::CMD_PUSH: begin
        if (stopped) begin
          op.status = bef_pkg::ST_STOPPED;
        end else if (held_k >= cap_eff) begin
          op.status = bef_pkg::ST_FULL;
        end else begin
          seq_count_next    = seq_count + bef_pkg::SEQ_W'(1);
          held_next         = held_inc;
          if (held_inc > peak) begin
            peak_next = held_inc;
          end
          op.status         = bef_pkg::ST_ACCEPTED;
          op.payload        = request.payload;
          op.seq_num        = seq_count_next;
          op.occupancy      = bef_pkg::FIELD7_W'(held_inc);
          op.high_watermark = bef_pkg::FIELD7_W'(peak_next);
        end
      end
      bef_pkg::CMD_POP: begin
        if (held == '0) begin
          op.status = bef_pkg::ST_EMPTY;
        end else begin
          op.status = bef_pkg::ST_ITEM;
          op.count  = pop_count;
          held_next = held - CW'(pop_count);
        end
      end
      bef_pkg::CMD_STOP: begin
        stopped_next = 1'b1;
        op.status    = bef_pkg::ST_STOPPED;
      end
      default: begin
        stopped_next = 1'b1;
        held_next    = '0;
        op.status    = bef_pkg::ST_DISCARDED;
        op.occupancy = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= bef_pkg::CAPACITY_RESET;
      held      <= '0;
      peak      <= '0;
      seq_count <= '0;
      stopped   <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        held      <= held_next;
        peak      <= peak_next;
        seq_count <= seq_count_next;
        stopped   <= stopped_next;
      end
    end
  end

endmodule

>>> src/bef_queue.sv
// Short operation queue between the front and back ends of the bounded
// event FIFO. Depends on bef_pkg for the operation type and depth.
module bef_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  bef_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output bef_pkg::op_t head_op
);

  localparam int PW = $clog2(bef_pkg::QUEUE_DEPTH);
  localparam int NW = $clog2(bef_pkg::QUEUE_DEPTH + 1);

  bef_pkg::op_t  slots [bef_pkg::QUEUE_DEPTH];
  logic [PW-1:0] head, tail;
  logic [NW-1:0] fill;

  assign full      = (fill == NW'(bef_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head_op   = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        tail <= tail + PW'(1);
      end
      if (pop) begin
        head <= head + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + NW'(1);
      end else if (pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

>>> src/bef_back.sv
// Back end of the bounded event FIFO: holds the event ring, carries out
// queued operations in order and drives the registered result. Depends on bef_pkg.
module bef_back #(
  parameter int RING_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  input  bef_pkg::op_t  op,
  output logic          op_take,
  output logic          result_valid,
  output bef_pkg::res_t result
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int FW = bef_pkg::FIELD7_W;

  logic [bef_pkg::PAYLOAD_W-1:0] mem_payload  [RING_DEPTH];
  logic [bef_pkg::SEQ_W-1:0]     mem_sequence [RING_DEPTH];

  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [FW-1:0] left, occ, peak;

  logic          pop_start, issue, do_write;
  logic [FW-1:0] cur_cnt, cur_occ, cur_peak;

  logic [bef_pkg::PAYLOAD_W-1:0] rd_payload;
  logic [bef_pkg::SEQ_W-1:0]     rd_sequence;
  logic                          out_from_mem;
  logic [2:0]                    out_status;
  logic [bef_pkg::SEQ_W-1:0]     out_sequence;
  logic                          out_last;
  logic [FW-1:0]                 out_occ, out_peak;

  // A new operation is taken only when no pop batch is still running.
  assign op_take   = op_valid && (left == '0);
  assign pop_start = op_take && (op.status == bef_pkg::ST_ITEM);
  assign issue     = pop_start || (left != '0);
  assign do_write  = op_take && (op.status == bef_pkg::ST_ACCEPTED);
  assign cur_cnt   = pop_start ? op.count : left;
  assign cur_occ   = pop_start ? op.occupancy : occ;
  assign cur_peak  = pop_start ? op.high_watermark : peak;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem_payload[wr_ptr]  <= op.payload;
      mem_sequence[wr_ptr] <= op.seq_num;
    end
    if (issue) begin
      rd_payload  <= mem_payload[rd_ptr];
      rd_sequence <= mem_sequence[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_from_mem <= 1'b1;
      out_status   <= bef_pkg::ST_ITEM;
      out_sequence <= '0;
      out_last     <= (cur_cnt == FW'(1));
      out_occ      <= cur_occ - FW'(1);
      out_peak     <= cur_peak;
    end else begin
      out_from_mem <= 1'b0;
      out_status   <= op.status;
      out_sequence <= op.seq_num;
      out_last     <= 1'b1;
      out_occ      <= op.occupancy;
      out_peak     <= op.high_watermark;
    end
    if (issue) begin
      occ  <= cur_occ - FW'(1);
      peak <= cur_peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      left         <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= op_take || issue;
      if (do_write) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (issue) begin
        rd_ptr <= rd_ptr + AW'(1);
        left   <= cur_cnt - FW'(1);
      end else if (op_take && (op.status == bef_pkg::ST_DISCARDED)) begin
        rd_ptr <= wr_ptr;
      end
    end
  end

  always_comb begin
    result.status         = out_status;
    result.item_payload   = out_from_mem ? rd_payload : '0;
    result.item_sequence  = out_from_mem ? rd_sequence : out_sequence;
    result.last           = out_last;
    result.occupancy      = out_occ;
    result.high_watermark = out_peak;
  end

endmodule

>>> src/bounded_event_fifo_unit.sv
// Top level of the bounded event FIFO: front end, operation queue and back end.
// Depends on bef_pkg, bef_front, bef_queue and bef_back.
//
// Use: a command transaction (push, pop batch, stop, discard) is taken at a
// rising edge where start is high and busy is low; its fields travel in the
// request struct. Each result appears on the result struct for exactly one
// cycle with result_valid high; the receiver cannot stall, so nothing waits.
// The capacity register is written over cfg_valid/cfg_ready/cfg_data; ready
// is always high, and writes belong in idle periods only.
// Path: with the queue empty and the back end idle, a taken command is first
// queued; the back end then takes it from the queue and registers its result.
// Throughput: the front end classifies one command per cycle and hands it to
// a four-entry operation queue; busy rises only while that queue is full.
// The back end drains the queue in order and takes no new command while a pop
// batch is still running; a pop of n events gives n results, since it reads one
// ring entry per cycle through the single read port of the event memory.
// Reset (synchronous, active high) empties the queue, clears the fill count,
// watermark, sequence counter and stop flag, and sets the capacity to 64.
// Ring contents are not cleared; only written entries are ever read.
module bounded_event_fifo_unit #(
  parameter int RING_DEPTH = 64,
  parameter int MAX_BATCH  = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  bef_pkg::req_t                 request,
  output logic                          result_valid,
  output bef_pkg::res_t                 result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bef_pkg::FIELD7_W-1:0]  cfg_data
);

  logic         accept;
  logic         ops_full;
  logic         queue_not_empty;
  logic         queue_pop;
  bef_pkg::op_t front_op;
  bef_pkg::op_t head_op;

  // The block only stalls commands when the operation queue has no room.
  assign busy      = ops_full;
  assign accept    = start && !ops_full;
  assign cfg_ready = 1'b1;

  bef_front #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_BATCH  (MAX_BATCH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .request   (request),
    .cfg_write (cfg_valid),
    .cfg_data  (cfg_data),
    .op        (front_op)
  );

  bef_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_op   (front_op),
    .full      (ops_full),
    .pop       (queue_pop),
    .not_empty (queue_not_empty),
    .head_op   (head_op)
  );

  bef_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (queue_not_empty),
    .op           (head_op),
    .op_take      (queue_pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bounded_event_fifo_unit. Command transactions go in
// through start/busy, and every result is scored against a FIFO model kept here.
// Depends on bef_pkg and the RTL of the block; reads no files.
module tb;

  localparam int RING_SLOTS    = 64;
  localparam int BATCH_CEILING = 64;
  // Once nothing is owed the block is idle, so the quiet window at the end
  // is enough to catch stray results.
  localparam int QUIET_CYCLES  = 20;
  localparam int REPORT_LIMIT  = 30;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  bef_pkg::req_t                request = '0;
  logic                         result_valid;
  bef_pkg::res_t                result;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [bef_pkg::FIELD7_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  bounded_event_fifo_unit #(
    .RING_DEPTH(RING_SLOTS),
    .MAX_BATCH (BATCH_CEILING)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .result_valid(result_valid),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // Shadow copy of the FIFO. The ring holds payloads and their sequence
  // stamps; pointers are six bits wide so they wrap with the ring.
  logic [bef_pkg::PAYLOAD_W-1:0] ring_payload [RING_SLOTS];
  logic [bef_pkg::SEQ_W-1:0]     ring_stamp [RING_SLOTS];
  logic [5:0]                    wr_ptr = '0;
  logic [5:0]                    rd_ptr = '0;
  logic [bef_pkg::FIELD7_W-1:0]  fill = '0;
  logic [bef_pkg::FIELD7_W-1:0]  peak = '0;
  logic [bef_pkg::SEQ_W-1:0]     stamp_counter = '0;
  bit                            halted = 1'b0;
  logic [bef_pkg::FIELD7_W-1:0]  capacity_reg = bef_pkg::CAPACITY_RESET;

  // Results still owed by the block, oldest first.
  bef_pkg::res_t owed_results[$];
  int unsigned   error_count = 0;
  // Chance, in percent, that a burst of idle cycles precedes a command.
  int            idle_percent = 0;

  // Builds one result from the current fill and watermark of the model.
  function automatic bef_pkg::res_t fifo_result(input bef_pkg::status_t st,
                                                input logic [bef_pkg::PAYLOAD_W-1:0] pay,
                                                input logic [bef_pkg::SEQ_W-1:0] stamp,
                                                input logic is_last);
    bef_pkg::res_t r;
    r.status         = st;
    r.item_payload   = pay;
    r.item_sequence  = stamp;
    r.last           = is_last;
    r.occupancy      = fill;
    r.high_watermark = peak;
    return r;
  endfunction

  // Appends one result to the end of the owed list.
  function automatic void owe_result(input bef_pkg::res_t r);
    owed_results.insert(owed_results.size(), r);
  endfunction

  // Applies one accepted command to the model and queues what it must produce.
  task automatic predict_fifo_results(input bef_pkg::req_t rq);
    logic [bef_pkg::FIELD7_W-1:0] limit;
    logic [bef_pkg::FIELD7_W-1:0] take;
    case (bef_pkg::cmd_t'(rq.cmd))
      bef_pkg::CMD_PUSH: begin
        // Capacity zero acts as one; anything past the ring saturates.
        limit = capacity_reg;
        if (limit == '0) limit = 7'd1;
        if (limit > RING_SLOTS) limit = 7'(RING_SLOTS);
        // A stopped queue refuses pushes even when it is also full.
        if (halted) begin
          owe_result(fifo_result(bef_pkg::ST_STOPPED, '0, '0, 1'b1));
        end else if (fill >= limit) begin
          owe_result(fifo_result(bef_pkg::ST_FULL, '0, '0, 1'b1));
        end else begin
          stamp_counter        = stamp_counter + 64'd1;
          ring_payload[wr_ptr] = rq.payload;
          ring_stamp[wr_ptr]   = stamp_counter;
          wr_ptr               = wr_ptr + 6'd1;
          fill                 = fill + 7'd1;
          if (fill > peak) peak = fill;
          owe_result(fifo_result(bef_pkg::ST_ACCEPTED, '0, stamp_counter, 1'b1));
        end
      end
      bef_pkg::CMD_POP: begin
        take = rq.max_batch;
        if (take == '0) take = 7'd1;
        if (take > BATCH_CEILING) take = 7'(BATCH_CEILING);
        if (fill == '0) begin
          owe_result(fifo_result(bef_pkg::ST_EMPTY, '0, '0, 1'b1));
        end else begin
          if (take > fill) take = fill;
          for (int k = 0; k < int'(take); k++) begin
            fill = fill - 7'd1;
            owe_result(fifo_result(bef_pkg::ST_ITEM, ring_payload[rd_ptr],
                                   ring_stamp[rd_ptr], k == int'(take) - 1));
            rd_ptr = rd_ptr + 6'd1;
          end
        end
      end
      bef_pkg::CMD_STOP: begin
        halted = 1'b1;
        owe_result(fifo_result(bef_pkg::ST_STOPPED, '0, '0, 1'b1));
      end
      default: begin
        // Discard stops the queue and drops everything held.
        halted = 1'b1;
        rd_ptr = wr_ptr;
        fill   = '0;
        owe_result(fifo_result(bef_pkg::ST_DISCARDED, '0, '0, 1'b1));
      end
    endcase
  endtask

  function automatic void compare_field(input string tag, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, want, got);
    end
  endfunction

  // Result scoring. The receiver cannot stall, so every strobe is a
  // transaction; outputs are sampled at the edge that ends the strobe cycle.
  always @(posedge clk) begin
    bef_pkg::res_t want;
    if (!rst && result_valid) begin
      if (owed_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: unexpected result, expected none, actual status %h seq %h",
                   $time, result.status, result.item_sequence);
      end else begin
        want = owed_results.pop_front();
        compare_field("status", 64'(want.status), 64'(result.status));
        compare_field("item_payload", 64'(want.item_payload), 64'(result.item_payload));
        compare_field("item_sequence", want.item_sequence, result.item_sequence);
        compare_field("last", 64'(want.last), 64'(result.last));
        compare_field("occupancy", 64'(want.occupancy), 64'(result.occupancy));
        compare_field("high_watermark", 64'(want.high_watermark),
                      64'(result.high_watermark));
      end
    end
  end

  // Sends one command transaction. Start is left high on return so that
  // back-to-back commands keep it asserted; only an idle burst or a wait
  // for quiet lowers it, and never in the same time step as a raise.
  task automatic issue_command(input bef_pkg::cmd_t c,
                               input logic [bef_pkg::PAYLOAD_W-1:0] pay,
                               input logic [bef_pkg::FIELD7_W-1:0] batch);
    if (idle_percent > 0 && $urandom_range(99) < idle_percent) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    request <= '{cmd: c, payload: pay, max_batch: batch};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    predict_fifo_results(request);
  endtask

  // Stops issuing and waits until every owed result has come back.
  task automatic wait_results_done();
    start <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  // Capacity writes happen only with the block idle.
  task automatic write_capacity(input logic [bef_pkg::FIELD7_W-1:0] value);
    wait_results_done();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    capacity_reg = value;
  endtask

  // Pops on an empty queue, payload extremes, and batch sizes of zero and
  // above the ceiling.
  task automatic test_pop_edges();
    idle_percent = 25;
    issue_command(bef_pkg::CMD_POP, $urandom, 7'd5);
    issue_command(bef_pkg::CMD_PUSH, '0, 7'd0);
    issue_command(bef_pkg::CMD_PUSH, '1, 7'd127);
    issue_command(bef_pkg::CMD_PUSH, 32'h5A5A_A5A5, 7'd3);
    issue_command(bef_pkg::CMD_POP, $urandom, 7'd0);
    issue_command(bef_pkg::CMD_POP, $urandom, 7'd127);
    issue_command(bef_pkg::CMD_POP, $urandom, 7'd64);
  endtask

  // Capacity of one and zero, and a capacity lowered below the current fill.
  task automatic test_capacity_edges();
    idle_percent = 25;
    write_capacity(7'd1);
    issue_command(bef_pkg::CMD_PUSH, $urandom, 7'($urandom));
    issue_command(bef_pkg::CMD_PUSH, $urandom, 7'($urandom));
    write_capacity(7'd0);
    issue_command(bef_pkg::CMD_PUSH, $urandom, 7'($urandom));
    issue_command(bef_pkg::CMD_POP, $urandom, 7'd1);
    issue_command(bef_pkg::CMD_PUSH, $urandom, 7'($urandom));
    write_capacity(7'd64);
    repeat (3) issue_command(bef_pkg::CMD_PUSH, $urandom, 7'($urandom));
    // Four are held now; a limit of two must refuse pushes but drop nothing.
    write_capacity(7'd2);
    issue_command(bef_pkg::CMD_PUSH, $urandom, 7'($urandom));
    issue_command(bef_pkg::CMD_POP, $urandom, 7'd64);
    repeat (3) issue_command(bef_pkg::CMD_PUSH, $urandom, 7'($urandom));
  endtask

  // Mixed push and pop traffic under one capacity. Segments lean toward
  // filling or toward draining so the queue swings between empty and full.
  task automatic test_random_traffic(input int count,
                                     input logic [bef_pkg::FIELD7_W-1:0] cap,
                                     input int idle);
    logic [bef_pkg::FIELD7_W-1:0] batch;
    int                           push_weight;
    write_capacity(cap);
    idle_percent = idle;
    push_weight  = 70;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) push_weight = $urandom_range(1) ? 80 : 35;
      if ($urandom_range(99) < push_weight) begin
        issue_command(bef_pkg::CMD_PUSH, $urandom, 7'($urandom));
      end else begin
        case ($urandom_range(9))
          0: batch = 7'($urandom);
          1: batch = 7'(BATCH_CEILING);
          default: batch = 7'($urandom_range(8));
        endcase
        issue_command(bef_pkg::CMD_POP, $urandom, batch);
      end
    end
  endtask

  // Stop is terminal, so this runs last: a stop on a full queue, pushes after
  // it, repeated stops, draining pops, then discards with items held and not.
  task automatic test_stop_and_discard();
    idle_percent = 0;
    write_capacity(7'd3);
    repeat (4) issue_command(bef_pkg::CMD_PUSH, $urandom, 7'($urandom));
    issue_command(bef_pkg::CMD_STOP, $urandom, 7'($urandom));
    issue_command(bef_pkg::CMD_PUSH, $urandom, 7'($urandom));
    issue_command(bef_pkg::CMD_STOP, $urandom, 7'($urandom));
    issue_command(bef_pkg::CMD_POP, $urandom, 7'd1);
    issue_command(bef_pkg::CMD_PUSH, $urandom, 7'($urandom));
    issue_command(bef_pkg::CMD_DISCARD, $urandom, 7'($urandom));
    issue_command(bef_pkg::CMD_DISCARD, $urandom, 7'($urandom));
    issue_command(bef_pkg::CMD_POP, $urandom, 7'd5);
    issue_command(bef_pkg::CMD_PUSH, $urandom, 7'($urandom));
    // Any command mix once stopped: only empty, stopped and discarded remain.
    repeat (20) issue_command(bef_pkg::cmd_t'($urandom_range(3)), $urandom, 7'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_pop_edges();
    test_capacity_edges();
    test_random_traffic(90, 7'd64, 30);
    test_random_traffic(80, 7'd127, 0);
    test_random_traffic(80, 7'($urandom_range(2, 63)), 50);
    test_random_traffic(60, 7'd1, 20);
    test_random_traffic(40, 7'd0, 30);
    test_random_traffic(40, 7'($urandom), 0);
    test_stop_and_discard();
    wait_results_done();
    // Any result beyond the owed ones would show up within this window.
    repeat (QUIET_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
